// ===== hw/rtl/rmq_pkg.sv =====
// Shared constants, widths and types of the rotation matrix to quaternion block.
`timescale 1ns / 1ps

package rmq_pkg;

  // Fixed point scale of matrix elements and quaternion parts
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned ONE       = 1 << FRAC_BITS;

  // Field widths
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned QW_W   = 15;
  localparam int unsigned QV_W   = 16;

  // Trace combination: ONE plus three sign-extended elements
  localparam int unsigned SUM_W   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int unsigned COMB_W  = SUM_W - 1;
  localparam int unsigned RAD_RAW = COMB_W + FRAC_BITS;
  localparam int unsigned RAD_W   = RAD_RAW + (RAD_RAW % 2);
  localparam int unsigned RT_W    = RAD_W / 2;
  localparam int unsigned REM_W   = RT_W + 3;

  // Lanes, one per quaternion component
  localparam int unsigned LANES  = 4;
  localparam int unsigned LANE_W = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Y = 2;
  localparam int unsigned LANE_Z = 3;

  // Pipeline depth from start to done: front stage, root stages, merge stage
  localparam int unsigned LATENCY = RT_W + 2;

  typedef struct packed {
    logic signed [ELEM_W-1:0] north_x;
    logic signed [ELEM_W-1:0] north_y;
    logic signed [ELEM_W-1:0] north_z;
    logic signed [ELEM_W-1:0] east_x;
    logic signed [ELEM_W-1:0] east_y;
    logic signed [ELEM_W-1:0] east_z;
    logic signed [ELEM_W-1:0] down_x;
    logic signed [ELEM_W-1:0] down_y;
    logic signed [ELEM_W-1:0] down_z;
  } item_t;

  typedef struct packed {
    logic        [QW_W-1:0] quat_w;
    logic signed [QV_W-1:0] quat_x;
    logic signed [QV_W-1:0] quat_y;
    logic signed [QV_W-1:0] quat_z;
  } result_t;

  // Sign of one vector part, taken from its element difference
  typedef struct packed {
    logic zero;
    logic neg;
  } sgn_t;

  // Sideband that travels beside the root lanes
  typedef struct packed {
    logic valid;
    sgn_t x;
    sgn_t y;
    sgn_t z;
  } side_t;

endpackage

// ===== hw/rtl/rmq_front.sv =====
// Front stage: trace combinations, clamping, radicands and sign codes.
`timescale 1ns / 1ps

module rmq_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  rmq_pkg::item_t                        item_i,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::RAD_W-1:0] rad_o,
  output rmq_pkg::side_t                        side_o
);
  import rmq_pkg::*;

  logic signed [SUM_W-1:0] one_s, r00, r11, r22;
  logic signed [SUM_W-1:0] comb [LANES];
  logic [LANES-1:0][RAD_W-1:0] rad_d, rad_q;
  side_t side_d, side_q;

  // Sign-extend the diagonal
  assign one_s = SUM_W'(ONE);
  assign r00   = SUM_W'(item_i.north_x);
  assign r11   = SUM_W'(item_i.east_y);
  assign r22   = SUM_W'(item_i.down_z);

  // Form the four trace combinations
  assign comb[LANE_W] = one_s + r00 + r11 + r22;
  assign comb[LANE_X] = one_s + r00 - r11 - r22;
  assign comb[LANE_Y] = one_s - r00 + r11 - r22;
  assign comb[LANE_Z] = one_s - r00 - r11 + r22;

  // Clamp at zero and scale up by the fraction width
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (comb[l] <= 0) begin
        rad_d[l] = '0;
      end else begin
        rad_d[l] = RAD_W'({comb[l][COMB_W-1:0], {FRAC_BITS{1'b0}}});
      end
    end
  end

  // Signs come from element comparisons, no subtraction needed
  always_comb begin
    side_d.valid  = valid_i;
    side_d.x.zero = (item_i.east_z == item_i.down_y);
    side_d.x.neg  = (item_i.east_z <  item_i.down_y);
    side_d.y.zero = (item_i.down_x == item_i.north_z);
    side_d.y.neg  = (item_i.down_x <  item_i.north_z);
    side_d.z.zero = (item_i.north_y == item_i.east_x);
    side_d.z.neg  = (item_i.north_y <  item_i.east_x);
  end

  // Radicands carry no reset
  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_d;
    end
  end

  assign rad_o  = rad_q;
  assign side_o = side_q;

endmodule

// ===== hw/rtl/rmq_sqrt_lane.sv =====
// Pipelined floor integer square root, one root bit per stage.
`timescale 1ns / 1ps

module rmq_sqrt_lane (
  input  logic                     clk_i,
  input  logic [rmq_pkg::RAD_W-1:0] rad_i,
  output logic [rmq_pkg::RT_W-1:0]  root_o
);
  import rmq_pkg::*;

  logic [REM_W-1:0] rem_q  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];
  logic [RAD_W-1:0] rad_q  [RT_W];

  for (genvar s = 0; s < RT_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_in, cur, trial;
    logic [RT_W-1:0]  root_in;
    logic [RAD_W-1:0] rad_in;
    logic             ge;

    // Take the previous stage, or the fresh radicand at the head
    if (s == 0) begin : g_head
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_body
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? (cur - trial) : cur;
      root_q[s] <= {root_in[RT_W-2:0], ge};
      rad_q[s]  <= {rad_in[RAD_W-3:0], 2'b00};
    end
  end

  assign root_o = root_q[RT_W-1];

endmodule

// ===== hw/rtl/rmq_merge.sv =====
// Merge stage: halve and saturate the roots, apply signs, register the result word.
`timescale 1ns / 1ps

module rmq_merge (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [rmq_pkg::LANES-1:0][rmq_pkg::RT_W-1:0] root_i,
  input  rmq_pkg::side_t                       side_i,
  output logic                                 done_o,
  output rmq_pkg::result_t                     result_o
);
  import rmq_pkg::*;

  logic [LANES-1:0][RT_W-2:0] mag;
  logic [QV_W-1:0] vx, vy, vz;
  result_t result_d, result_q;
  logic    done_q;

  // Halve each root and saturate at one
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (root_i[l][RT_W-1:1] > (RT_W-1)'(ONE)) begin
        mag[l] = (RT_W-1)'(ONE);
      end else begin
        mag[l] = root_i[l][RT_W-1:1];
      end
    end
  end

  assign vx = QV_W'(mag[LANE_X]);
  assign vy = QV_W'(mag[LANE_Y]);
  assign vz = QV_W'(mag[LANE_Z]);

  // Apply signs; a zero difference forces the part to zero
  always_comb begin
    result_d.quat_w = QW_W'(mag[LANE_W]);
    result_d.quat_x = side_i.x.zero ? '0 : (side_i.x.neg ? -vx : vx);
    result_d.quat_y = side_i.y.zero ? '0 : (side_i.y.neg ? -vy : vy);
    result_d.quat_z = side_i.z.zero ? '0 : (side_i.z.neg ? -vz : vz);
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_i.valid;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// Top level: rotation matrix in Q1.14 to quaternion, four square-root lanes.
// One matrix word is taken on every cycle that start is high (busy stays low),
// and its quaternion appears on result_o with done_o high for exactly one
// cycle, once it has passed through every stage of the pipeline: one stage
// forms the four trace combinations, RT_W stages of each root lane resolve
// one root bit apiece, and one merge stage applies saturation and signs.
// Throughput is one word per cycle; results come out in order and must be
// taken on the cycle they are shown, as the receiver cannot stall them.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rmq_pkg::item_t   item_i,
  output logic             done_o,
  output rmq_pkg::result_t result_o
);
  import rmq_pkg::*;

  logic [LANES-1:0][RAD_W-1:0] rad;
  logic [LANES-1:0][RT_W-1:0]  root;
  side_t side_front;
  side_t side_q [RT_W];

  // Every stage moves on each cycle, so a new word is always welcome
  assign busy = 1'b0;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .item_i  (item_i),
    .rad_o   (rad),
    .side_o  (side_front)
  );

  // One root lane per quaternion component
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    rmq_sqrt_lane u_lane (
      .clk_i  (clk_i),
      .rad_i  (rad[l]),
      .root_o (root[l])
    );
  end

  // Delay the sideband alongside the root stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < RT_W; s++) begin
        side_q[s] <= '0;
      end
    end else begin
      side_q[0] <= side_front;
      for (int s = 1; s < RT_W; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  rmq_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .root_i   (root),
    .side_i   (side_q[RT_W-1]),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Every accepted word comes out after the fixed latency
  a_start_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##LATENCY done_o)
    else $error("accepted word did not complete on time");

  // No result without a word accepted at the matching cycle
  a_done_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without an accepted word");

  // Scalar part saturates at one
  a_w_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.quat_w <= QW_W'(ONE)))
    else $error("scalar part above one");

  // Equal off-diagonal pair forces x to zero
  a_x_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(item_i.east_z == item_i.down_y, LATENCY) |-> (result_o.quat_x == '0))
    else $error("x part not zero on equal elements");

endmodule

// ===== bench/rotation_matrix_to_quaternion_tb.sv =====
// Self-checking bench for the rotation matrix to quaternion block.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int Q = ONE;
  localparam int RANDOM_WORDS = 2000;

  // Pending matrix word, with an optional request to drain the pipe first
  typedef struct {
    item_t word;
    bit    drain;
  } pending_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  pending_t matrix_queue[$];
  result_t  quat_expected[$];
  pending_t head_word;
  result_t  quat_want;
  bit       took_word = 1'b0;
  int       words_sent = 0;
  int       words_directed = 0;
  int       quats_checked = 0;
  int       rotations_made = 0;
  int       mismatches = 0;

  rotation_matrix_to_quaternion uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Print one mismatch line and count it
  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Floor square root by setting one root bit at a time from the top
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Magnitude of one component: clamp, scale, root, halve, saturate at one
  function automatic longint unsigned trace_half_root(longint comb);
    longint unsigned mag;
    if (comb <= 0) return 0;
    mag = floor_root(longint'(comb) << FRAC_BITS) >> 1;
    return (mag > Q) ? Q : mag;
  endfunction

  // Sign a magnitude from its element difference; zero difference forces zero
  function automatic logic [QV_W-1:0] apply_sign(longint unsigned mag, longint diff);
    longint unsigned neg;
    neg = 64'd0 - mag;
    if (diff == 0) return '0;
    if (diff < 0) return neg[QV_W-1:0];
    return mag[QV_W-1:0];
  endfunction

  // Quaternion that one matrix word must produce
  function automatic result_t quat_from_matrix(item_t m);
    longint one;
    longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
    longint unsigned mw, mx, my, mz;
    result_t q;
    one = longint'(Q);
    r00 = m.north_x; r10 = m.north_y; r20 = m.north_z;
    r01 = m.east_x;  r11 = m.east_y;  r21 = m.east_z;
    r02 = m.down_x;  r12 = m.down_y;  r22 = m.down_z;
    mw = trace_half_root(one + r00 + r11 + r22);
    mx = trace_half_root(one + r00 - r11 - r22);
    my = trace_half_root(one - r00 + r11 - r22);
    mz = trace_half_root(one - r00 - r11 + r22);
    q.quat_w = mw[QW_W-1:0];
    q.quat_x = apply_sign(mx, r21 - r12);
    q.quat_y = apply_sign(my, r02 - r20);
    q.quat_z = apply_sign(mz, r10 - r01);
    return q;
  endfunction

  // Pack a row-major matrix into its North, East and Down columns
  function automatic item_t make_matrix(int r00, int r01, int r02,
                                        int r10, int r11, int r12,
                                        int r20, int r21, int r22);
    item_t m;
    m.north_x = 16'(r00); m.north_y = 16'(r10); m.north_z = 16'(r20);
    m.east_x  = 16'(r01); m.east_y  = 16'(r11); m.east_z  = 16'(r21);
    m.down_x  = 16'(r02); m.down_y  = 16'(r12); m.down_z  = 16'(r22);
    return m;
  endfunction

  task automatic queue_matrix(item_t m, bit drain);
    pending_t p;
    p.word  = m;
    p.drain = drain;
    matrix_queue.push_back(p);
  endtask

  function automatic real rand_unit();
    return real'($urandom_range(2000000, 0)) / 1.0e6 - 1.0;
  endfunction

  function automatic int to_q14(real v);
    int k;
    k = $rtoi(v * real'(Q) + ((v >= 0.0) ? 0.5 : -0.5));
    if (k > Q) k = Q;
    if (k < -Q) k = -Q;
    return k;
  endfunction

  // Build a genuine rotation matrix from a random unit quaternion
  function automatic item_t random_rotation();
    real a, b, c, d, n;
    int e[9];
    a = rand_unit(); b = rand_unit(); c = rand_unit(); d = rand_unit();
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 0.1) begin
      a = 1.0; b = 0.0; c = 0.0; d = 0.0; n = 1.0;
    end
    a = a / n; b = b / n; c = c / n; d = d / n;
    e[0] = to_q14(1.0 - 2.0 * (c * c + d * d));
    e[1] = to_q14(2.0 * (b * c - a * d));
    e[2] = to_q14(2.0 * (b * d + a * c));
    e[3] = to_q14(2.0 * (b * c + a * d));
    e[4] = to_q14(1.0 - 2.0 * (b * b + d * d));
    e[5] = to_q14(2.0 * (c * d - a * b));
    e[6] = to_q14(2.0 * (b * d - a * c));
    e[7] = to_q14(2.0 * (c * d + a * b));
    e[8] = to_q14(1.0 - 2.0 * (b * b + c * c));
    // in one matrix of ten, nudge every element by up to three LSBs so diffs land near zero
    if ($urandom_range(9, 0) == 0) begin
      for (int i = 0; i < 9; i++) e[i] += $urandom_range(6, 0) - 3;
    end
    return make_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
  endfunction

  // Directed: identity, zero, -I, half turns, +/-quarter turns, extremes, patterns, LSB steps
  task automatic queue_directed();
    queue_matrix(make_matrix(Q, 0, 0, 0, Q, 0, 0, 0, Q), 1'b0);
    queue_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    queue_matrix(make_matrix(Q, 0, 0, 0, -Q, 0, 0, 0, -Q), 1'b0);
    queue_matrix(make_matrix(-Q, 0, 0, 0, Q, 0, 0, 0, -Q), 1'b0);
    queue_matrix(make_matrix(-Q, 0, 0, 0, -Q, 0, 0, 0, Q), 1'b0);
    queue_matrix(make_matrix(-Q, 0, 0, 0, -Q, 0, 0, 0, -Q), 1'b0);
    queue_matrix(make_matrix(Q, 0, 0, 0, 0, -Q, 0, Q, 0), 1'b0);
    queue_matrix(make_matrix(Q, 0, 0, 0, 0, Q, 0, -Q, 0), 1'b0);
    queue_matrix(make_matrix(0, 0, Q, 0, Q, 0, -Q, 0, 0), 1'b0);
    queue_matrix(make_matrix(0, 0, -Q, 0, Q, 0, Q, 0, 0), 1'b0);
    queue_matrix(make_matrix(0, -Q, 0, Q, 0, 0, 0, 0, Q), 1'b0);
    queue_matrix(make_matrix(0, Q, 0, -Q, 0, 0, 0, 0, Q), 1'b0);
    // beyond +/-1.0: magnitudes saturate at one
    queue_matrix(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                             32767, 32767, 32767), 1'b0);
    queue_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768), 1'b0);
    queue_matrix(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767), 1'b0);
    queue_matrix(make_matrix(-32768, 32767, -32768, 32767, -32768, 32767,
                             -32768, 32767, -32768), 1'b0);
    // toggle every element bit with alternating patterns
    queue_matrix(make_matrix(16'h5555, -16'sh5556, 16'h5555, -16'sh5556, 16'h5555,
                             -16'sh5556, 16'h5555, -16'sh5556, 16'h5555), 1'b0);
    queue_matrix(make_matrix(-16'sh5556, 16'h5555, -16'sh5556, 16'h5555, -16'sh5556,
                             16'h5555, -16'sh5556, 16'h5555, -16'sh5556), 1'b0);
    // one-LSB differences of each sign
    queue_matrix(make_matrix(Q, 0, 1, 1, Q, 0, 0, 1, Q), 1'b0);
    queue_matrix(make_matrix(Q, 1, 0, 0, Q, 1, 1, 0, Q), 1'b1);
    words_directed = matrix_queue.size();
  endtask

  // Random words: half true rotations, then symmetric, in-range and raw noise
  task automatic queue_random();
    int e[9];
    int pick;
    item_t m;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        m = random_rotation();
        rotations_made++;
      end else begin
        for (int i = 0; i < 9; i++) begin
          if (pick < 85) e[i] = $urandom_range(2 * Q, 0) - Q;
          else e[i] = int'(16'($urandom));
        end
        // symmetric matrices force every vector part to zero
        if (pick < 60) begin
          e[3] = e[1]; e[6] = e[2]; e[7] = e[5];
        end
        m = make_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
      end
      queue_matrix(m, (n % 600) == 300);
    end
  endtask

  function automatic int unsigned sender_idle_pct();
    if (words_sent < 700) return 12;
    if (words_sent < 1400) return 63;
    return 0;
  endfunction

  // Driver: present the next word at the falling edge once the last one is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took_word) begin
      if (matrix_queue.size() == 0) begin
        start <= 1'b0;
      end else if (matrix_queue[0].drain && quat_expected.size() != 0) begin
        start <= 1'b0;
      end else if ($urandom_range(99, 0) < sender_idle_pct()) begin
        start <= 1'b0;
      end else begin
        head_word = matrix_queue.pop_front();
        item_i <= head_word.word;
        start  <= 1'b1;
        words_sent++;
      end
    end
  end

  // Monitor: check each result word, then record the word taken at this edge
  always @(posedge clk_i) begin
    took_word = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (quat_expected.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          quat_want = quat_expected.pop_front();
          if (result_o.quat_w !== quat_want.quat_w)
            report_mismatch($sformatf("quaternion %0d quat_w got %0d want %0d",
                            quats_checked, result_o.quat_w, quat_want.quat_w));
          if (result_o.quat_x !== quat_want.quat_x)
            report_mismatch($sformatf("quaternion %0d quat_x got %0d want %0d",
                            quats_checked, result_o.quat_x, quat_want.quat_x));
          if (result_o.quat_y !== quat_want.quat_y)
            report_mismatch($sformatf("quaternion %0d quat_y got %0d want %0d",
                            quats_checked, result_o.quat_y, quat_want.quat_y));
          if (result_o.quat_z !== quat_want.quat_z)
            report_mismatch($sformatf("quaternion %0d quat_z got %0d want %0d",
                            quats_checked, result_o.quat_z, quat_want.quat_z));
          quats_checked++;
        end
      end
      if (start && !busy) begin
        quat_expected.push_back(quat_from_matrix(item_i));
        took_word = 1'b1;
      end
    end
  end

  // Sequence: fill the queue, reset once, drain, then give the verdict
  initial begin
    queue_directed();
    queue_random();
    repeat (4) @(posedge clk_i);
    #0.5 rst_ni = 1'b1;
    while (matrix_queue.size() != 0 || start) @(posedge clk_i);
    while (quat_expected.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (quat_expected.size() != 0)
      report_mismatch($sformatf("%0d quaternions never arrived", quat_expected.size()));
    $display("Covered %0d matrix words (%0d directed, %0d true rotations) over three idling phases",
             words_sent, words_directed, rotations_made);
    $display("Checked %0d quaternions, %0d mismatches", quats_checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Timed out with %0d words pending and %0d results outstanding",
             matrix_queue.size(), quat_expected.size());
    $display("status: fail");
    $finish;
  end

endmodule
